// ===== hdl/nwc_pkg.sv =====
// ---------------------------------------------------------------------------
// Normalized window convolution package
// Shared widths, configuration and handshake types, and the size clamp.
// ---------------------------------------------------------------------------
package nwc_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int KERNEL_SIZE    = 3;
    localparam int KIDX_W         = $clog2(KERNEL_SIZE);

    localparam int PIXEL_W    = 8;
    localparam int COORD_W    = 10;
    localparam int VALUE_W    = 20;
    localparam int SIZE_W     = 13;
    localparam int CFG_SIZE_W = 11;
    localparam int KROW_W     = 24;
    localparam int KENT_W     = 8;
    localparam int COEF_W     = 12;
    localparam int PROD_W     = 17;
    localparam int MAG_W      = VALUE_W - 1;
    localparam int DIVISOR_W  = 11;
    localparam int DCNT_W     = $clog2(MAG_W);

    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int TDATA_W = 40;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MAC,
        S_DSET,
        S_DIV,
        S_PUSH_INT,
        S_PUSH_BRD
    } t_state;

    typedef struct packed {
        logic [CFG_SIZE_W-1:0] image_width;
        logic [CFG_SIZE_W-1:0] image_height;
        logic [KROW_W-1:0]     kernel_row_top;
        logic [KROW_W-1:0]     kernel_row_middle;
        logic [KROW_W-1:0]     kernel_row_bottom;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic load;
        logic mac_step;
        logic div_start;
        logic div_step;
        logic push_int;
        logic push_brd;
    } t_cmd;

    typedef struct packed {
        logic interior;
        logic border;
        logic mac_last;
        logic div_last;
        logic coef_zero;
        logic q_room;
    } t_sts;

    typedef struct packed {
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic [VALUE_W-1:0] value;
        logic               divide_error;
        logic               last_of_run;
    } t_result;

    // Out-of-range sizes act as the nearest legal size.
    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] maxv
    );
        logic [SIZE_W-1:0] res;
        if (v < SIZE_W'(3)) begin
            res = SIZE_W'(3);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== hdl/nwc_cfg.sv =====
// ---------------------------------------------------------------------------
// Configuration registers
// APB-style register file for image size and the three kernel rows.
// ---------------------------------------------------------------------------
module nwc_cfg
    import nwc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    localparam logic [2:0] IDX_WIDTH  = 3'd0;
    localparam logic [2:0] IDX_HEIGHT = 3'd1;
    localparam logic [2:0] IDX_KTOP   = 3'd2;
    localparam logic [2:0] IDX_KMID   = 3'd3;
    localparam logic [2:0] IDX_KBOT   = 3'd4;

    localparam logic [CFG_SIZE_W-1:0] RST_SIZE = CFG_SIZE_W'(4);
    localparam logic [KROW_W-1:0]     RST_KOUT = KROW_W'(66049);
    localparam logic [KROW_W-1:0]     RST_KMID = KROW_W'(132098);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[APB_AW-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width       <= RST_SIZE;
            r_cfg.image_height      <= RST_SIZE;
            r_cfg.kernel_row_top    <= RST_KOUT;
            r_cfg.kernel_row_middle <= RST_KMID;
            r_cfg.kernel_row_bottom <= RST_KOUT;
        end else if (wr_en) begin
            unique case (reg_idx)
                IDX_WIDTH:  r_cfg.image_width       <= pwdata[CFG_SIZE_W-1:0];
                IDX_HEIGHT: r_cfg.image_height      <= pwdata[CFG_SIZE_W-1:0];
                IDX_KTOP:   r_cfg.kernel_row_top    <= pwdata[KROW_W-1:0];
                IDX_KMID:   r_cfg.kernel_row_middle <= pwdata[KROW_W-1:0];
                IDX_KBOT:   r_cfg.kernel_row_bottom <= pwdata[KROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            IDX_WIDTH:  prdata = APB_DW'(r_cfg.image_width);
            IDX_HEIGHT: prdata = APB_DW'(r_cfg.image_height);
            IDX_KTOP:   prdata = APB_DW'(r_cfg.kernel_row_top);
            IDX_KMID:   prdata = APB_DW'(r_cfg.kernel_row_middle);
            IDX_KBOT:   prdata = APB_DW'(r_cfg.kernel_row_bottom);
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== hdl/nwc_ctrl.sv =====
// ---------------------------------------------------------------------------
// Convolution controller
// Sequences one pixel through load, multiply-accumulate, divide and output.
// ---------------------------------------------------------------------------
module nwc_ctrl
    import nwc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_sts.interior) begin
                    n_state = S_MAC;
                end else if (i_sts.border) begin
                    n_state = S_PUSH_BRD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MAC: begin
                o_cmd.mac_step = 1'b1;
                if (i_sts.mac_last) begin
                    n_state = S_DSET;
                end
            end
            S_DSET: begin
                // A zero kernel sum skips the divider and reports the raw sum.
                if (i_sts.coef_zero) begin
                    n_state = S_PUSH_INT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_PUSH_INT;
                end
            end
            S_PUSH_INT: begin
                if (i_sts.q_room) begin
                    o_cmd.push_int = 1'b1;
                    n_state        = i_sts.border ? S_PUSH_BRD : S_IDLE;
                end
            end
            S_PUSH_BRD: begin
                if (i_sts.q_room) begin
                    o_cmd.push_brd = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== hdl/nwc_dp.sv =====
// ---------------------------------------------------------------------------
// Convolution datapath
// Position counters, line stores, 3x3 window, serial MAC, restoring divider
// and a two-entry result queue.
// ---------------------------------------------------------------------------
module nwc_dp
    import nwc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_cmd               i_cmd,
    input  logic [PIXEL_W-1:0] i_pixel,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output t_result            o_result,
    output t_sts               o_sts
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RW      = $clog2(MAX_HEIGHT);
    localparam int Q_DEPTH = 2;
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // Position of the incoming pixel, including the wrap after a size change.
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic              col_wrap;
    logic [SIZE_W-1:0] row_tmp;
    logic [CW-1:0]     cur_col;
    logic [RW-1:0]     cur_row;
    logic [SIZE_W-1:0] col_inc;
    logic [SIZE_W-1:0] row_inc;
    logic              end_wrap;
    logic              border_now;
    logic              interior_now;

    logic [CW-1:0]      r_col_cnt;
    logic [RW-1:0]      r_row_cnt;
    logic [CW-1:0]      n_col_cnt;
    logic [RW-1:0]      n_row_cnt;
    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic [PIXEL_W-1:0] r_px;
    logic               r_interior;
    logic               r_border;

    logic [PIXEL_W-1:0] r_upper_line [MAX_WIDTH];
    logic [PIXEL_W-1:0] r_lower_line [MAX_WIDTH];
    logic [PIXEL_W-1:0] r_up_rd;
    logic [PIXEL_W-1:0] r_lo_rd;

    logic [PIXEL_W-1:0] r_win [KERNEL_SIZE][KERNEL_SIZE];

    logic [KIDX_W-1:0]        r_mi;
    logic [KIDX_W-1:0]        r_mj;
    logic signed [VALUE_W-1:0] r_acc;
    logic signed [COEF_W-1:0]  r_coef;
    logic [KROW_W-1:0]        krow;
    logic signed [KENT_W-1:0] kent;
    logic [PIXEL_W-1:0]       pix;
    logic signed [PROD_W-1:0] kent_x;
    logic signed [PROD_W-1:0] pix_x;
    logic signed [PROD_W-1:0] prod;

    logic [VALUE_W-1:0]     acc_abs;
    logic [COEF_W-1:0]      coef_abs;
    logic [MAG_W-1:0]       r_quo;
    logic [DIVISOR_W-1:0]   r_rem;
    logic [DIVISOR_W-1:0]   r_dvs;
    logic [DCNT_W-1:0]      r_dcnt;
    logic                   r_neg;
    logic [DIVISOR_W:0]     shifted;
    logic [DIVISOR_W:0]     diff;
    logic                   ge;
    logic [VALUE_W-1:0]     q_ext;
    logic [VALUE_W-1:0]     int_value;
    logic                   coef_zero;

    t_result     res_int;
    t_result     res_brd;
    t_result     r_q [Q_DEPTH];
    logic        r_wp;
    logic        r_rp;
    logic [QC_W-1:0] r_cnt;
    logic        push;
    logic        pop;

    // ---------------- position ----------------
    assign w_eff    = clamp_size(SIZE_W'(i_cfg.image_width), SIZE_W'(MAX_WIDTH));
    assign h_eff    = clamp_size(SIZE_W'(i_cfg.image_height), SIZE_W'(MAX_HEIGHT));
    assign col_wrap = SIZE_W'(r_col_cnt) >= w_eff;
    assign row_tmp  = col_wrap ? SIZE_W'(r_row_cnt) + SIZE_W'(1) : SIZE_W'(r_row_cnt);
    assign cur_col  = col_wrap ? '0 : r_col_cnt;
    assign cur_row  = (row_tmp >= h_eff) ? '0 : RW'(row_tmp);
    assign col_inc  = SIZE_W'(cur_col) + SIZE_W'(1);
    assign row_inc  = SIZE_W'(cur_row) + SIZE_W'(1);
    assign end_wrap = col_inc >= w_eff;

    always_comb begin
        if (end_wrap) begin
            n_col_cnt = '0;
            n_row_cnt = (row_inc >= h_eff) ? '0 : RW'(row_inc);
        end else begin
            n_col_cnt = CW'(col_inc);
            n_row_cnt = cur_row;
        end
    end

    assign border_now   = (cur_row == '0) || (SIZE_W'(cur_row) == h_eff - SIZE_W'(1)) ||
                          (cur_col == '0) || (SIZE_W'(cur_col) == w_eff - SIZE_W'(1));
    assign interior_now = (cur_row >= RW'(2)) && (cur_col >= CW'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (i_cmd.take) begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_col      <= cur_col;
            r_row      <= cur_row;
            r_px       <= i_pixel;
            r_interior <= interior_now;
            r_border   <= border_now;
        end
    end

    // ---------------- line stores ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_lo_rd               <= r_lower_line[cur_col];
            r_lower_line[cur_col] <= i_pixel;
        end
    end

    // The upper row takes the old lower-row value in the cycle after the lower row is written.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_up_rd <= r_upper_line[cur_col];
        end
        if (i_cmd.load) begin
            r_upper_line[r_col] <= r_lo_rd;
        end
    end

    // ---------------- window ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < KERNEL_SIZE; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= r_up_rd;
            r_win[1][2] <= r_lo_rd;
            r_win[2][2] <= r_px;
        end
    end

    // ---------------- multiply-accumulate ----------------
    // Window entry (i,j) is weighted by the kernel rotated by 180 degrees.
    always_comb begin
        unique case (r_mi)
            KIDX_W'(0): krow = i_cfg.kernel_row_bottom;
            KIDX_W'(1): krow = i_cfg.kernel_row_middle;
            default:    krow = i_cfg.kernel_row_top;
        endcase
        unique case (r_mj)
            KIDX_W'(0): kent = $signed(krow[23:16]);
            KIDX_W'(1): kent = $signed(krow[15:8]);
            default:    kent = $signed(krow[7:0]);
        endcase
    end

    assign pix    = r_win[r_mi][r_mj];
    assign kent_x = PROD_W'(kent);
    assign pix_x  = PROD_W'($signed({1'b0, pix}));
    assign prod   = kent_x * pix_x;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc  <= '0;
            r_coef <= '0;
            r_mi   <= '0;
            r_mj   <= '0;
        end else if (i_cmd.mac_step) begin
            r_acc  <= r_acc + VALUE_W'(prod);
            r_coef <= r_coef + COEF_W'(kent);
            if (r_mj == KIDX_W'(KERNEL_SIZE - 1)) begin
                r_mj <= '0;
                r_mi <= r_mi + KIDX_W'(1);
            end else begin
                r_mj <= r_mj + KIDX_W'(1);
            end
        end
    end

    // ---------------- divider ----------------
    // Restoring division on magnitudes, one quotient bit per cycle; the sign
    // is applied at the end, which truncates toward zero.
    assign acc_abs  = r_acc[VALUE_W-1] ? VALUE_W'(-r_acc) : VALUE_W'(r_acc);
    assign coef_abs = r_coef[COEF_W-1] ? COEF_W'(-r_coef) : COEF_W'(r_coef);
    assign shifted  = {r_rem, r_quo[MAG_W-1]};
    assign ge       = shifted >= {1'b0, r_dvs};
    assign diff     = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg  <= r_acc[VALUE_W-1] ^ r_coef[COEF_W-1];
            r_quo  <= acc_abs[MAG_W-1:0];
            r_dvs  <= coef_abs[DIVISOR_W-1:0];
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            r_quo  <= {r_quo[MAG_W-2:0], ge};
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
    end

    assign coef_zero = (r_coef == '0);
    assign q_ext     = {1'b0, r_quo};
    assign int_value = coef_zero ? VALUE_W'(r_acc) : (r_neg ? VALUE_W'(-q_ext) : q_ext);

    // ---------------- results ----------------
    always_comb begin
        res_int.out_row      = COORD_W'(r_row - RW'(1));
        res_int.out_col      = COORD_W'(r_col - CW'(1));
        res_int.value        = int_value;
        res_int.divide_error = coef_zero;
        res_int.last_of_run  = ~r_border;
        res_brd.out_row      = COORD_W'(r_row);
        res_brd.out_col      = COORD_W'(r_col);
        res_brd.value        = VALUE_W'(r_px);
        res_brd.divide_error = 1'b0;
        res_brd.last_of_run  = 1'b1;
    end

    assign push        = i_cmd.push_int | i_cmd.push_brd;
    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid & i_out_ready;
    assign o_result    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd.push_int ? res_int : res_brd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + QC_W'(1);
                2'b01:   r_cnt <= r_cnt - QC_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // ---------------- status ----------------
    always_comb begin
        o_sts.interior  = r_interior;
        o_sts.border    = r_border;
        o_sts.mac_last  = (r_mi == KIDX_W'(KERNEL_SIZE - 1)) &&
                          (r_mj == KIDX_W'(KERNEL_SIZE - 1));
        o_sts.div_last  = (r_dcnt == DCNT_W'(MAG_W - 1));
        o_sts.coef_zero = coef_zero;
        o_sts.q_room    = (r_cnt != QC_W'(Q_DEPTH));
    end

endmodule

// ===== hdl/normalized_window_convolution_top.sv =====
// Sequence: a border-only result is queued after the load step; an interior result
//   first passes the nine-step MAC and the 19-step divider, skipped for a zero kernel sum.
// Flow: one pixel is in flight at a time; a new pixel is accepted only in idle, after the
//   last one's results are queued, and a full result queue stalls the push.
// Reset: synchronous active low; clears the counters, controller, result queue and
//   restores the default size and kernel. The line stores are not cleared.
// ---------------------------------------------------------------------------
// Normalized window convolution top level
// 3x3 kernel convolution over a raster pixel stream, normalized by the
// kernel sum, with border pixels passed through.
// ---------------------------------------------------------------------------
module normalized_window_convolution_top
    import nwc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [PIXEL_W-1:0] s_axis_tdata,   // [7:0] pixel
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [9:0] out_row, [19:10] out_col,
                                               // [39:20] value
    output logic               m_axis_tlast,
    output logic               m_axis_tuser,   // [0] divide_error
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_sts    sts;
    t_result result;

    nwc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    nwc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    nwc_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_pixel     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (result),
        .o_sts       (sts)
    );

    assign m_axis_tdata = {result.value, result.out_col, result.out_row};
    assign m_axis_tlast = result.last_of_run;
    assign m_axis_tuser = result.divide_error;

endmodule

// ===== hdl/nwc_checker.sv =====
// ---------------------------------------------------------------------------
// Port checker
// Temporal checks on the stream ports of the convolution block.
// ---------------------------------------------------------------------------
module nwc_checker
    import nwc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // One pixel is in flight at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second pixel accepted while busy");

    // An interior result that is not last is directly followed by its border pixel.
    a_border_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("border result missing after interior result");

    // That border pixel lies one row below the interior result.
    a_border_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tdata[9:0] == $past(m_axis_tdata[9:0]) + 10'd1)
        else $error("border result row mismatch");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind normalized_window_convolution_top nwc_checker u_nwc_checker (.*);
